// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the fingerprint set RTL.
// Needs signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/fdset_pkg.sv -----
// Package for the fingerprint dedup set: constants, item structs, codes.
// No dependencies; imported by fdset_hasher and fingerprint_dedup_set_core.
package fdset_pkg;

  localparam int TABLE_SLOTS = 4096;
  localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = 13;
  localparam int WORD_W      = 32;
  localparam int HASH_W      = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [HASH_W-1:0]  FNV_BASIS    = 64'hCBF29CE484222325;
  // FNV prime is 2^40 + 0x1B3: a shift plus a narrow multiply.
  localparam int                 FNV_SHIFT    = 40;
  localparam logic [HASH_W-1:0]  FNV_PRIME_LO = 64'h00000000000001B3;
  localparam logic [WORD_W-1:0]  COORD_OFFSET = 32'd10000;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_PRESENT  = 2'd1,
    STAT_CAP      = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_PROBE
  } fsm_state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word_value;
    logic                     is_coordinate;
    logic                     end_of_record;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [HASH_W-1:0]    fingerprint;
    logic [COUNT_W-1:0]   visited_count;
  } out_item_t;

endpackage

// ----- hdl/fdset_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fdset_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fdset_hasher.sv -----
// Running FNV-1a 64 hash over the words of a record.
// Depends on fdset_pkg.
module fdset_hasher
  import fdset_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_item_t          item,
  output logic [HASH_W-1:0] fingerprint
);

  logic [HASH_W-1:0] running_hash;
  logic [WORD_W-1:0] word_adj;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] hash_next;

  always_comb begin
    word_adj  = item.is_coordinate ? (WORD_W'(item.word_value) + COORD_OFFSET)
                                   : WORD_W'(item.word_value);
    mixed     = running_hash ^ {{(HASH_W-WORD_W){1'b0}}, word_adj};
    hash_next = (mixed << FNV_SHIFT) + HASH_W'(mixed * FNV_PRIME_LO);
  end

  // Fold one word per accept; on the last word latch the fingerprint
  // and return to the offset basis.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (accept) begin
      running_hash <= item.end_of_record ? FNV_BASIS : hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.end_of_record) begin
      fingerprint <= (hash_next == '0) ? HASH_W'(1) : hash_next;
    end
  end

endmodule

// ----- hdl/fingerprint_dedup_set_core.sv -----
// Top level of the fingerprint dedup set: hashing, probe control, table.
// Depends on fdset_pkg, fdset_hasher, fdset_ram and assert_macros.svh.
//
//  channel   ports                          handshake
//  -------   -----------------------------  -----------------------------
//  input     start, busy, item              taken when start && !busy
//  result    done, result                   one-cycle strobe, no stall
//  config    cfg_we, cfg_wdata (state_cap)  written when cfg_we
//
// A word without the end mark leaves busy low: the next item may follow
// at once. A word with the end mark keeps busy high through the start
// state and the probe state, where the linear probe examines table slots
// one slot per cycle out of the single read port; the result strobe comes
// in the cycle after the last probe. With the state cap reached, no slot is
// probed and the home slot read issued in the start state is dropped.
// After reset, busy stays high while the table is cleared one slot per
// cycle; config writes are taken during that time.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module fingerprint_dedup_set_core
  import fdset_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item,
  output logic               done,
  output out_item_t          result,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  fsm_state_t         state, state_next;
  logic [COUNT_W-1:0] state_cap;
  logic [COUNT_W-1:0] count, count_next;
  logic [SLOT_AW-1:0] clr_addr;
  logic [SLOT_AW-1:0] probe_addr, probe_addr_next;
  logic [SLOT_AW-1:0] probe_cnt, probe_cnt_next;

  logic               accept;
  logic [HASH_W-1:0]  fp;
  logic               cap_hit;
  logic               slot_empty, slot_match, last_probe;

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr, ram_raddr;
  logic [HASH_W-1:0]  ram_wdata, ram_rdata;

  logic               done_next;
  status_t            status_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  fdset_hasher u_hasher (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .fingerprint (fp)
  );

  fdset_ram #(
    .WIDTH (HASH_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slot data read last cycle belongs to probe_addr.
  assign cap_hit    = (state_cap != '0) && (count >= state_cap);
  assign slot_empty = (ram_rdata == '0);
  assign slot_match = (ram_rdata == fp);
  assign last_probe = (probe_cnt == SLOT_AW'(TABLE_SLOTS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SLOT_AW'(TABLE_SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && item.end_of_record) state_next = ST_START;
      end
      ST_START: begin
        state_next = cap_hit ? ST_IDLE : ST_PROBE;
      end
      ST_PROBE: begin
        if (slot_empty || slot_match || last_probe) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: table port, probe pointers, result.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = probe_addr;
    ram_wdata       = fp;
    ram_raddr       = probe_addr + 1'b1;
    probe_addr_next = probe_addr;
    probe_cnt_next  = probe_cnt;
    count_next      = count;
    done_next       = 1'b0;
    status_next     = STAT_INSERTED;
    case (state)
      ST_CLEAR: begin
        // Sweep zeros through the table.
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_START: begin
        // Read the home slot; report at once if the cap is reached.
        ram_raddr       = fp[SLOT_AW-1:0];
        probe_addr_next = fp[SLOT_AW-1:0];
        probe_cnt_next  = '0;
        if (cap_hit) begin
          done_next   = 1'b1;
          status_next = STAT_CAP;
        end
      end
      ST_PROBE: begin
        // The read of the following slot goes out speculatively.
        if (slot_empty) begin
          ram_we      = 1'b1;
          count_next  = (count != COUNT_MAX) ? count + 1'b1 : count;
          done_next   = 1'b1;
          status_next = STAT_INSERTED;
        end else if (slot_match) begin
          done_next   = 1'b1;
          status_next = STAT_PRESENT;
        end else if (last_probe) begin
          done_next   = 1'b1;
          status_next = STAT_FULL;
        end else begin
          probe_addr_next = probe_addr + 1'b1;
          probe_cnt_next  = probe_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      state_cap <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_we) state_cap <= cfg_wdata;
    end
  end

  // Hold the result payload for the strobe cycle.
  always_ff @(posedge clk) begin
    probe_addr <= probe_addr_next;
    probe_cnt  <= probe_cnt_next;
    if (done_next) begin
      result.status        <= status_next;
      result.fingerprint   <= fp;
      result.visited_count <= count_next;
    end
  end

  `ASSERT_IMPL(a_fp_nonzero, done, result.fingerprint != '0, "zero fingerprint reported")
  `ASSERT_IMPL(a_insert_only_empty, (state == ST_PROBE) && ram_we, slot_empty,
               "insert into an occupied slot")
  `ASSERT_IMPL(a_done_source, done,
               ($past(state) == ST_START) || ($past(state) == ST_PROBE),
               "result without a lookup")
  `ASSERT_NEXT(a_result_idle, done_next, state == ST_IDLE,
               "lookup did not return to idle")

endmodule
